>>> sv/blzd_pkg.sv
// Shared constants and types for the backward LZSS decompressor.
// No dependencies; used by the top level, the checker and the testbench tracker.
package blzd_pkg;

	// history ring depth default (bytes)
	localparam int unsigned HISTORY_DEPTH_DEF = 16384;

	// token field sizes
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 5;   // match length 3..18
	localparam int unsigned DIST_W = 13;  // match distance 3..4098
	localparam int unsigned FLAG_CNT_W = 4;  // 0..8 pending flag bits
	localparam int unsigned COUNT_W = 32;

	// token constants
	localparam logic [LEN_W-1:0]  MIN_LEN  = LEN_W'(3);
	localparam logic [DIST_W-1:0] MIN_DIST = DIST_W'(3);
	localparam logic [FLAG_CNT_W-1:0] FLAGS_PER_BYTE = FLAG_CNT_W'(8);
	localparam logic [LEN_W-1:0]  LAST_COPY = LEN_W'(1);

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

>>> sv/blzd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the decompressor history ring.
module blzd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/backward_lzss_decompressor.sv
// Top level of the backward LZSS decompressor: token decoder, copy sequencer
// and output register. Depends on blzd_pkg and blzd_ram.
//
// Usage:
// Compressed bytes enter on in_valid/in_ready/in_byte, one request per byte,
// in software read order. Decompressed bytes leave on out_valid/out_ready with
// out_byte, last_of_run (final byte caused by one input byte) and finished
// (byte count has reached output_length). output_length is written through
// cfg_wen/cfg_wdata while the block is idle.
// Sequencing: a flag byte or first match byte is taken while idle and gives
// no output. A literal goes from the literal state into the output register,
// and the block is ready again the cycle after it loads the output register.
// A match latches its token as its second byte is taken and keeps the block
// busy while it forms the first ring address in the match start state, then
// copies one byte per cycle while the output register is free, from the single
// read port of the history RAM; one shared subtractor forms each source address.
// Reset: all control state clears and the ring reads as zero until written
// (a wrap flag tracks which slots are still unwritten), so there is no
// clearing pass. When the receiver stalls, the output register holds its
// byte and the copy sequencer waits; no byte is dropped.
module backward_lzss_decompressor #(
	parameter int unsigned HISTORY_DEPTH = blzd_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [blzd_pkg::COUNT_W-1:0]        cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [blzd_pkg::BYTE_W-1:0]         in_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [blzd_pkg::BYTE_W-1:0]         out_byte,
	output logic                                last_of_run,
	output logic                                finished
);

	import blzd_pkg::*;

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);
	localparam logic [AW:0] DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LIT,
		S_MSTART,
		S_COPY
	} state_t;

	state_t              state_q;
	logic [COUNT_W-1:0]  out_len_q;
	logic [COUNT_W-1:0]  bw_q;
	logic [AW-1:0]       wi_q;
	logic                wrapped_q;
	byte_t               flag_q;
	logic [FLAG_CNT_W-1:0] bits_left_q;
	logic                phase_q;
	byte_t               mfb_q;
	byte_t               lit_q;
	logic [DIST_W-1:0]   dist_q;
	logic [LEN_W-1:0]    cnt_q;
	logic                zero_s1;
	logic                out_valid_q;
	byte_t               out_byte_q;
	logic                last_q;
	logic                finished_q;

	logic                accept;
	logic                out_free;
	logic                emit;
	logic                done;
	byte_t               emit_byte;
	logic [COUNT_W-1:0]  bw_inc;
	logic [AW-1:0]       wi_inc;
	logic                wrap_next;
	logic [AW-1:0]       wi_sel;
	logic                wrap_sel;
	logic [AW:0]         diff;
	logic                borrow;
	logic [AW-1:0]       src_addr;
	logic                ram_re;
	byte_t               ram_rdata;

	// handshake and emit conditions
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign emit     = out_free && ((state_q == S_LIT) || (state_q == S_COPY));
	assign done     = (bw_q >= out_len_q);

	// byte being emitted this cycle
	always_comb begin
		if (state_q == S_LIT) begin
			emit_byte = lit_q;
		end else if (zero_s1) begin
			emit_byte = '0;
		end else begin
			emit_byte = ram_rdata;
		end
	end

	// counters for the emitted byte
	assign bw_inc    = (bw_q == '1) ? bw_q : bw_q + COUNT_W'(1);
	assign wi_inc    = (wi_q == LAST_SLOT) ? '0 : wi_q + AW'(1);
	assign wrap_next = wrapped_q || (wi_q == LAST_SLOT);

	// shared source address subtractor: write slot minus distance, mod depth
	assign wi_sel   = (state_q == S_MSTART) ? wi_q : wi_inc;
	assign wrap_sel = (state_q == S_MSTART) ? wrapped_q : wrap_next;
	assign diff     = {1'b0, wi_sel} - {{(AW+1-DIST_W){1'b0}}, dist_q};
	assign borrow   = diff[AW];
	assign src_addr = borrow ? AW'(diff + DEPTH_EXT) : diff[AW-1:0];

	// read for the first match byte, then one ahead while copying
	assign ram_re = (state_q == S_MSTART) ||
		((state_q == S_COPY) && out_free && (cnt_q != LAST_COPY));

	blzd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (emit),
		.waddr(wi_q),
		.wdata(emit_byte),
		.re   (ram_re),
		.raddr(src_addr),
		.rdata(ram_rdata)
	);

	// sequencer, decoder state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_len_q   <= '0;
			bw_q        <= '0;
			wi_q        <= '0;
			wrapped_q   <= 1'b0;
			flag_q      <= '0;
			bits_left_q <= '0;
			phase_q     <= 1'b0;
			mfb_q       <= '0;
			lit_q       <= '0;
			dist_q      <= '0;
			cnt_q       <= '0;
			zero_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			last_q      <= 1'b0;
			finished_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				out_len_q <= cfg_wdata;
			end

			// output register loads on emit, otherwise drains when taken
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// emitted byte: output, ring write, counters
			if (emit) begin
				out_byte_q  <= emit_byte;
				finished_q  <= (bw_inc >= out_len_q);
				bw_q        <= bw_inc;
				wi_q        <= wi_inc;
				wrapped_q   <= wrap_next;
			end

			case (state_q)
				S_IDLE: begin
					if (accept && !done) begin
						if (bits_left_q == '0) begin
							flag_q      <= in_byte;
							bits_left_q <= FLAGS_PER_BYTE;
							phase_q     <= 1'b0;
						end else if (!phase_q && !flag_q[BYTE_W-1]) begin
							lit_q       <= in_byte;
							flag_q      <= {flag_q[BYTE_W-2:0], 1'b0};
							bits_left_q <= bits_left_q - FLAG_CNT_W'(1);
							state_q     <= S_LIT;
						end else if (!phase_q) begin
							mfb_q   <= in_byte;
							phase_q <= 1'b1;
						end else begin
							cnt_q       <= LEN_W'(mfb_q[BYTE_W-1:4]) + MIN_LEN;
							dist_q      <= {mfb_q[3:0], in_byte} + MIN_DIST;
							flag_q      <= {flag_q[BYTE_W-2:0], 1'b0};
							bits_left_q <= bits_left_q - FLAG_CNT_W'(1);
							phase_q     <= 1'b0;
							state_q     <= S_MSTART;
						end
					end
				end
				S_LIT: begin
					if (emit) begin
						last_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MSTART: begin
					zero_s1 <= !wrap_sel && borrow;
					state_q <= S_COPY;
				end
				S_COPY: begin
					if (emit) begin
						last_q <= (cnt_q == LAST_COPY);
						cnt_q  <= cnt_q - LEN_W'(1);
						if (cnt_q == LAST_COPY) begin
							state_q <= S_IDLE;
						end else begin
							zero_s1 <= !wrap_sel && borrow;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign finished    = finished_q;

endmodule

>>> sv/blzd_checker.sv
// Port-level checks for the backward LZSS decompressor, bound to the top level.
// Depends on blzd_pkg and backward_lzss_decompressor.
module blzd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [blzd_pkg::BYTE_W-1:0]  out_byte,
	input logic                         last_of_run,
	input logic                         finished
);

	import blzd_pkg::*;

	// a stalled output holds its byte and flags
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
			$stable(last_of_run) && $stable(finished))
		else $error("output changed while stalled");

	// a byte that is not the last of its run means a copy is still going
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> !in_ready)
		else $error("ready during a match copy");

	// no output appears in the cycle right after a request is taken
	a_no_instant_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("output rose right after input request");

endmodule

bind backward_lzss_decompressor blzd_checker u_blzd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.last_of_run(last_of_run),
	.finished   (finished)
);

>>> tb/sv/tb_blzd_tracker.sv
// Expected-output tracker for the backward LZSS decompressor testbench:
// decodes every accepted request on its own copy of the state and checks outputs.
// Depends on blzd_pkg for the byte type, ring depth and token constants.
package tb_blzd_tracker_pkg;
	import blzd_pkg::*;

	typedef struct packed {
		byte_t data;
		logic  last;
		logic  fin;
	} out_rec_t;

	class blzd_output_tracker;
		// decoder state mirrored from the block
		byte_t       ring [HISTORY_DEPTH_DEF];
		int unsigned wr_pos;
		byte_t       flags;
		logic [3:0]  flags_left;
		bit          second_due;
		byte_t       first_tok;
		logic [31:0] written;
		logic [31:0] out_len;

		// bytes of the current request, then every byte still owed by the block
		out_rec_t    run_q [$];
		out_rec_t    pending_bytes [$];

		int          errors;
		int          inputs_taken;
		int          bytes_checked;
		int          matches_done;

		function new();
			foreach (ring[i]) ring[i] = '0;
			wr_pos        = 0;
			flags         = '0;
			flags_left    = '0;
			second_due    = 1'b0;
			first_tok     = '0;
			written       = '0;
			out_len       = '0;
			errors        = 0;
			inputs_taken  = 0;
			bytes_checked = 0;
			matches_done  = 0;
		endfunction

		function void set_length(logic [31:0] v);
			out_len = v;
		endfunction

		function bit length_reached();
			return written >= out_len;
		endfunction

		function int pending();
			return pending_bytes.size();
		endfunction

		// write one byte to the ring and note it as owed
		function void put_byte(byte_t b);
			out_rec_t rec;
			ring[wr_pos] = b;
			wr_pos = (wr_pos + 1) % HISTORY_DEPTH_DEF;
			if (written != 32'hFFFF_FFFF)
				written++;
			rec.data = b;
			rec.last = 1'b0;
			rec.fin  = length_reached();
			run_q.push_back(rec);
		endfunction

		// decode one accepted request
		function void take_request(byte_t b);
			logic [4:0]  run_len;
			logic [12:0] back_dist;
			int unsigned src;
			out_rec_t    rec;
			inputs_taken++;
			// past the configured length the byte is dropped
			if (length_reached())
				return;
			// flag byte
			if (flags_left == 0) begin
				flags      = b;
				flags_left = FLAGS_PER_BYTE;
				second_due = 1'b0;
				return;
			end
			// first byte of a match
			if (!second_due && flags[7]) begin
				first_tok  = b;
				second_due = 1'b1;
				return;
			end
			run_q.delete();
			if (!second_due) begin
				put_byte(b);
			end else begin
				run_len   = {1'b0, first_tok[7:4]} + MIN_LEN;
				back_dist = {1'b0, first_tok[3:0], b} + MIN_DIST;
				// byte by byte, so an overlapping copy reads its own output
				for (int j = 0; j < run_len; j++) begin
					src = (wr_pos + HISTORY_DEPTH_DEF - back_dist) % HISTORY_DEPTH_DEF;
					put_byte(ring[src]);
				end
				matches_done++;
			end
			flags      = flags << 1;
			flags_left = flags_left - 1'b1;
			second_due = 1'b0;
			foreach (run_q[i]) begin
				rec      = run_q[i];
				rec.last = (i == run_q.size() - 1);
				pending_bytes.push_back(rec);
			end
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		// compare one output byte with the oldest one owed
		task check_byte(byte_t data, logic last, logic fin);
			out_rec_t want;
			if (pending_bytes.size() == 0) begin
				report($sformatf("output byte %02h with nothing owed", data));
				return;
			end
			want = pending_bytes.pop_front();
			bytes_checked++;
			if (data !== want.data)
				report($sformatf("byte %0d: out_byte %02h, want %02h",
					bytes_checked, data, want.data));
			if (last !== want.last)
				report($sformatf("byte %0d: last_of_run %b, want %b",
					bytes_checked, last, want.last));
			if (fin !== want.fin)
				report($sformatf("byte %0d: finished %b, want %b",
					bytes_checked, fin, want.fin));
		endtask
	endclass

endpackage

>>> tb/sv/tb_top.sv
// Top of the backward LZSS decompressor testbench: clock, reset, request drivers,
// output monitor and the directed and random byte streams.
// Depends on blzd_pkg, tb_blzd_tracker_pkg and backward_lzss_decompressor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import blzd_pkg::*;
	import tb_blzd_tracker_pkg::*;

	localparam int unsigned RX_HOLD_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES  = 40;
	localparam int unsigned RANDOM_ITEMS   = 160;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_wen   = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	byte_t              in_byte   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	byte_t              out_byte;
	logic               last_of_run;
	logic               finished;

	bit tx_gaps     = 1'b1;
	bit rx_gaps     = 1'b1;
	bit rx_hold_req = 1'b0;
	int rand_items  = 0;
	int length_writes = 0;

	blzd_output_tracker tracker;

	always #10 clk = ~clk;

	backward_lzss_decompressor uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_of_run(last_of_run),
		.finished   (finished)
	);

	// output side: random back-pressure, plus one long hold-off on request
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (rx_hold_req) begin
				out_ready   <= 1'b0;
				hold_left   = RX_HOLD_CYCLES;
				rx_hold_req = 1'b0;
			end else begin
				out_ready <= !rx_gaps || ($urandom_range(0, 99) >= 16);
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_byte(out_byte, last_of_run, finished);
	end

	// one compressed byte as a request, with an occasional gap before it
	task automatic send_byte(input byte_t b);
		if (tx_gaps && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 40);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.take_request(b);
	endtask

	// stop sending until every owed byte has come out, then let the block settle
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [31:0] v);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tracker.set_length(v);
		length_writes++;
	endtask

	// next random byte shaped by where the decoder stands
	function automatic byte_t pick_token_byte();
		byte_t b;
		b = byte_t'($urandom);
		// flag byte, or plain noise
		if (tracker.flags_left == 0 || $urandom_range(0, 99) < 15)
			return b;
		if (tracker.second_due) begin
			// short distances read recent history
			if ($urandom_range(0, 1) != 0)
				b[7:4] = 4'h0;
		end else if (tracker.flags[7]) begin
			if ($urandom_range(0, 3) != 0)
				b[3:0] = 4'h0;
		end
		return b;
	endfunction

	initial begin : stimulus
		logic [31:0] len;
		int          phase;
		int          phase_items;
		tracker = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero length out of reset: every byte is dropped
		write_length(32'd0);
		send_byte(8'hFF);
		send_byte(8'h00);
		drain_and_settle();

		write_length(32'hFFFF_FFFF);
		// two matches on the untouched ring, then six literals
		send_byte(8'hC0);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_byte(8'h01);
		send_byte(8'h80);
		// overlapping longest match, then a far one that wraps the ring
		send_byte(8'hC2);
		send_byte(8'hF0);
		send_byte(8'h00);
		send_byte(8'h0F);
		send_byte(8'h01);
		drain_and_settle();

		// stop two bytes later; the next byte is dropped
		write_length(tracker.written + 32'd2);
		send_byte(8'h3C);
		send_byte(8'hC3);
		send_byte(8'h77);
		drain_and_settle();

		// resume, and let a match run past the new length
		write_length(tracker.written + 32'd3);
		send_byte(8'h99);
		send_byte(8'h66);
		send_byte(8'h50);
		send_byte(8'h04);
		send_byte(8'hEE);

		// random phases, each with its own length
		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			drain_and_settle();
			case (phase % 5)
				0:       len = tracker.written + $urandom_range(1, 8);
				1:       len = tracker.written + $urandom_range(60, 600);
				2:       len = 32'hFFFF_FFFF;
				3:       len = (phase == 3) ? 32'd0 : tracker.written;
				default: len = tracker.written + $urandom_range(200, 2000);
			endcase
			write_length(len);
			phase_items = 0;
			while (!tracker.length_reached() && phase_items < 60
					&& rand_items < RANDOM_ITEMS) begin
				// a stretch in the middle runs without gaps on either side
				tx_gaps = !(rand_items >= 100 && rand_items < 150);
				rx_gaps = tx_gaps;
				if (rand_items == 40)
					rx_hold_req = 1'b1;
				send_byte(pick_token_byte());
				phase_items++;
				rand_items++;
			end
			// bytes past the end are dropped
			if (tracker.length_reached())
				repeat ($urandom_range(1, 2)) send_byte(byte_t'($urandom));
			phase++;
		end

		drain_and_settle();
		$display("run: %0d requests (%0d random), %0d output bytes checked, %0d matches",
			tracker.inputs_taken, rand_items, tracker.bytes_checked, tracker.matches_done);
		$display("run: %0d length settings incl. zero, full range, early stop and resume",
			length_writes);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("backward_lzss_decompressor verification clean");
		end else begin
			$display("backward_lzss_decompressor verification failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("backward_lzss_decompressor verification failed");
		$finish;
	end

endmodule
